>>> rtl/ddp_pkg.sv
package ddp_pkg;

  // Default widths of the counting and fixed point arithmetic.
  localparam int PWM_COUNT_BITS_DEF = 12;
  localparam int FRACTION_BITS_DEF  = 14;

  // Channel register map: first register of channel n sits at base + stride * n.
  localparam int REG_BASE   = 6;
  localparam int REG_STRIDE = 4;

  // Fixed widths of the item fields.
  localparam int THROTTLE_W = 16;
  localparam int GAIN_W     = 16;
  localparam int TMAG_W     = THROTTLE_W + 1;
  localparam int PROD_W     = TMAG_W + GAIN_W;
  localparam int CHANS_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int ADDR_W     = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the configuration registers.
  localparam logic                PWM_MODE_RST       = 1'b0;
  localparam logic [GAIN_W-1:0]   SCALE_STRAIGHT_RST = 16'd16384;
  localparam logic [GAIN_W-1:0]   SCALE_ROTATION_RST = 16'd16384;
  localparam logic [CHANS_W-1:0]  LEFT_CHANNELS_RST  = 12'd528;
  localparam logic [CHANS_W-1:0]  RIGHT_CHANNELS_RST = 12'd1347;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_PWM_MODE       = 3'd0,
    CFG_SCALE_STRAIGHT = 3'd1,
    CFG_SCALE_ROTATION = 3'd2,
    CFG_LEFT_CHANNELS  = 3'd3,
    CFG_RIGHT_CHANNELS = 3'd4
  } cfg_idx_t;

  // Drive actions.
  localparam logic ACT_FORWARD = 1'b0;
  localparam logic ACT_ROTATE  = 1'b1;

  // One drive command.
  typedef struct packed {
    logic                          action;
    logic signed [THROTTLE_W-1:0]  throttle;
  } cmd_t;

  // One channel write.
  typedef struct packed {
    logic [ADDR_W-1:0]  register_address;
    logic [COUNT_W-1:0] on_count;
    logic [COUNT_W-1:0] off_count;
    logic               last;
  } result_t;

  // Direction of each motor for one command.
  typedef struct packed {
    logic left_fwd;
    logic right_fwd;
  } dir_t;

  // Configuration seen by the write sequencer.
  typedef struct packed {
    logic               pwm_mode;
    logic [CHANS_W-1:0] left_channels;
    logic [CHANS_W-1:0] right_channels;
  } back_cfg_t;

endpackage

>>> rtl/ddp_front.sv
module ddp_front
  import ddp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  cmd_t                          cmd,
  input  logic [GAIN_W-1:0]             scale_straight,
  input  logic [GAIN_W-1:0]             scale_rotation,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*FRACTION_BITS:0]      q_mag,
  output dir_t                          q_dir
);

  localparam int VW = 2 * FRACTION_BITS + 1;
  localparam int CW = (VW > PROD_W) ? VW : PROD_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << (2 * FRACTION_BITS);

  logic [THROTTLE_W-1:0] t;
  logic                  neg;
  logic [TMAG_W-1:0]     tmag;
  logic [GAIN_W-1:0]     gain;
  logic                  accept;

  logic                  s1_valid;
  logic [PROD_W-1:0]     s1_prod;
  logic                  s1_neg;
  logic                  s1_rot;

  logic [CW-1:0]         prod_c;
  logic [CW-1:0]         mag_c;
  logic                  prod_zero;
  logic                  prod_neg;

  // Throttle magnitude and gain selection ahead of the multiplier.
  assign t      = cmd.throttle;
  assign neg    = t[THROTTLE_W-1];
  assign tmag   = neg ? (TMAG_W'(1 << THROTTLE_W) - TMAG_W'(t)) : TMAG_W'(t);
  assign gain   = (cmd.action == ACT_ROTATE) ? scale_rotation : scale_straight;

  // The product stage holds while the queue is full.
  assign cmd_stall = s1_valid && q_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_push    = s1_valid && !q_full;

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_prod <= PROD_W'(tmag) * PROD_W'(gain);
      s1_neg  <= neg;
      s1_rot  <= (cmd.action == ACT_ROTATE);
    end
  end

  // Saturate the magnitude at one and work out each motor's direction.
  assign prod_c    = CW'(s1_prod);
  assign prod_zero = (s1_prod == '0);
  assign prod_neg  = s1_neg && !prod_zero;
  assign mag_c     = (prod_c > ONE_C) ? ONE_C : prod_c;
  assign q_mag     = mag_c[VW-1:0];

  always_comb begin
    q_dir.left_fwd = !prod_neg;
    if (s1_rot) begin
      q_dir.right_fwd = prod_neg || prod_zero;
    end else begin
      q_dir.right_fwd = !prod_neg;
    end
  end

endmodule

>>> rtl/ddp_queue.sv
module ddp_queue
  import ddp_pkg::*;
#(
  parameter int WIDTH = 2 * FRACTION_BITS_DEF + 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full  = (count == NW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("command queue read while empty");

endmodule

>>> rtl/ddp_back.sv
module ddp_back
  import ddp_pkg::*;
#(
  parameter int PWM_COUNT_BITS = PWM_COUNT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  back_cfg_t                cfg,
  input  logic                     q_valid,
  input  logic [2*FRACTION_BITS:0] q_mag,
  input  dir_t                     q_dir,
  output logic                     q_pop,
  output logic                     wr_valid,
  input  logic                     wr_stall,
  output result_t                  wr
);

  localparam int VW   = 2 * FRACTION_BITS + 1;
  localparam int DW   = VW + PWM_COUNT_BITS;
  localparam int CNTW = PWM_COUNT_BITS + 1;
  localparam int EW   = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam logic [VW-1:0]   ONE  = VW'(1) << (2 * FRACTION_BITS);
  localparam logic [CNTW-1:0] FULL = CNTW'(1) << PWM_COUNT_BITS;

  logic             motor;
  logic [1:0]       step;
  logic [1:0]       last_step;
  logic             step_end;
  logic             adv;

  logic             fwd;
  logic [CHANS_W-1:0] chans;
  logic [3:0]       chan;
  logic             mag_zero;
  logic [VW-1:0]    inv_mag;
  logic [VW-1:0]    v;
  logic [DW-1:0]    scaled;
  logic [CNTW-1:0]  on_cnt;
  logic [CNTW-1:0]  off_cnt;
  logic [EW-1:0]    on_ext;
  logic [EW-1:0]    off_ext;
  result_t          wr_next;

  // Writes per motor: three with a separate PWM channel, two otherwise.
  assign last_step = cfg.pwm_mode ? 2'd2 : 2'd1;
  assign step_end  = (step == last_step);
  assign adv       = q_valid && (!wr_valid || !wr_stall);
  assign q_pop     = adv && motor && step_end;

  // Select the motor's channels and direction.
  assign fwd      = motor ? q_dir.right_fwd : q_dir.left_fwd;
  assign chans    = motor ? cfg.right_channels : cfg.left_channels;
  assign mag_zero = (q_mag == '0);
  assign inv_mag  = ONE - q_mag;

  // Channel and level for this write.
  always_comb begin
    unique case (step)
      2'd0: begin
        chan = chans[3:0];
        if (cfg.pwm_mode) begin
          v = fwd ? '0 : ONE;
        end else begin
          v = (mag_zero || !fwd) ? ONE : inv_mag;
        end
      end
      2'd1: begin
        chan = chans[7:4];
        if (cfg.pwm_mode) begin
          v = fwd ? ONE : '0;
        end else begin
          v = (mag_zero || fwd) ? ONE : inv_mag;
        end
      end
      default: begin
        chan = chans[11:8];
        v    = q_mag;
      end
    endcase
  end

  // Level to on/off counts: full on, full off, or floor((full - 1) * v / one).
  assign scaled = (DW'(v) << PWM_COUNT_BITS) - DW'(v);

  always_comb begin
    if (v >= ONE) begin
      on_cnt  = FULL;
      off_cnt = '0;
    end else if (v == '0) begin
      on_cnt  = '0;
      off_cnt = FULL;
    end else begin
      on_cnt  = '0;
      off_cnt = CNTW'(scaled[2*FRACTION_BITS+PWM_COUNT_BITS-1:2*FRACTION_BITS]);
    end
  end

  assign on_ext  = EW'(on_cnt);
  assign off_ext = EW'(off_cnt);

  always_comb begin
    wr_next.register_address = ADDR_W'(REG_BASE) + ADDR_W'(chan) * ADDR_W'(REG_STRIDE);
    wr_next.on_count         = on_ext[COUNT_W-1:0];
    wr_next.off_count        = off_ext[COUNT_W-1:0];
    wr_next.last             = motor && step_end;
  end

  // Write sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor    <= 1'b0;
      step     <= '0;
      wr_valid <= 1'b0;
    end else if (adv) begin
      wr_valid <= 1'b1;
      if (step_end) begin
        step  <= '0;
        motor <= !motor;
      end else begin
        step <= step + 1'b1;
      end
    end else if (!wr_stall) begin
      wr_valid <= 1'b0;
    end
    if (adv) begin
      wr <= wr_next;
    end
  end

  a_pop_on_right: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (motor && step == last_step))
    else $error("command retired before its last right motor write");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (adv && !cfg.pwm_mode) |-> (step != 2'd2))
    else $error("input mode sequencer ran past two writes per motor");

endmodule

>>> rtl/differential_drive_pwm_command_unit.sv
// A command's first write passes the product register, a queue entry and the wr register.
// Six writes per command in PWM mode and four in input mode, one write per cycle from the
// back end sequencer while a command is queued and the receiver does not stall.
// A two entry queue lets the front take new commands while writes are still going out.
// Reset (rst, synchronous, active high) empties the pipeline and queue and loads
// the configuration registers with their default values.
module differential_drive_pwm_command_unit
  import ddp_pkg::*;
#(
  parameter int PWM_COUNT_BITS = PWM_COUNT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  wr_valid,
  input  logic                  wr_stall,
  output result_t               wr,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int VW = 2 * FRACTION_BITS + 1;
  localparam int QW = VW + $bits(dir_t);

  logic                pwm_mode;
  logic [GAIN_W-1:0]   scale_straight;
  logic [GAIN_W-1:0]   scale_rotation;
  logic [CHANS_W-1:0]  left_channels;
  logic [CHANS_W-1:0]  right_channels;

  cfg_idx_t            cfg_idx;
  logic                cfg_wr;
  back_cfg_t           back_cfg;

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  logic [VW-1:0]       push_mag;
  dir_t                push_dir;
  logic [QW-1:0]       q_head;
  logic [VW-1:0]       head_mag;
  dir_t                head_dir;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_mode       <= PWM_MODE_RST;
      scale_straight <= SCALE_STRAIGHT_RST;
      scale_rotation <= SCALE_ROTATION_RST;
      left_channels  <= LEFT_CHANNELS_RST;
      right_channels <= RIGHT_CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_PWM_MODE:       pwm_mode       <= pwdata[0];
        CFG_SCALE_STRAIGHT: scale_straight <= pwdata[GAIN_W-1:0];
        CFG_SCALE_ROTATION: scale_rotation <= pwdata[GAIN_W-1:0];
        CFG_LEFT_CHANNELS:  left_channels  <= pwdata[CHANS_W-1:0];
        CFG_RIGHT_CHANNELS: right_channels <= pwdata[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      CFG_PWM_MODE:       prdata = CFG_DATA_W'(pwm_mode);
      CFG_SCALE_STRAIGHT: prdata = CFG_DATA_W'(scale_straight);
      CFG_SCALE_ROTATION: prdata = CFG_DATA_W'(scale_rotation);
      CFG_LEFT_CHANNELS:  prdata = CFG_DATA_W'(left_channels);
      CFG_RIGHT_CHANNELS: prdata = CFG_DATA_W'(right_channels);
      default:            prdata = '0;
    endcase
  end

  assign back_cfg.pwm_mode       = pwm_mode;
  assign back_cfg.left_channels  = left_channels;
  assign back_cfg.right_channels = right_channels;

  // Front: throttle times gain, saturation and direction.
  ddp_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .scale_straight (scale_straight),
    .scale_rotation (scale_rotation),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_mag          (push_mag),
    .q_dir          (push_dir)
  );

  // Queue of classified commands.
  ddp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_mag, push_dir}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign head_mag = q_head[QW-1:$bits(dir_t)];
  assign head_dir = dir_t'(q_head[$bits(dir_t)-1:0]);

  // Back: channel write sequencer.
  ddp_back #(
    .PWM_COUNT_BITS (PWM_COUNT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (back_cfg),
    .q_valid  (q_valid),
    .q_mag    (head_mag),
    .q_dir    (head_dir),
    .q_pop    (q_pop),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

endmodule

>>> tb/differential_drive_pwm_command_unit_test.sv
module differential_drive_pwm_command_unit_test
  import ddp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed point unity of the throttle times gain product, and the full count code.
  localparam longint unsigned UNITY = 64'd1 << (2 * FRACTION_BITS_DEF);
  localparam longint unsigned FULL_COUNT = 64'd1 << PWM_COUNT_BITS_DEF;
  // First register index past the end of the register map.
  localparam int CFG_UNMAPPED = 5;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // Predicts the channel writes of each drive command and checks the block's writes.
  class pwm_write_scoreboard;
    bit pwm_mode = PWM_MODE_RST;
    bit [GAIN_W-1:0] gain_straight = SCALE_STRAIGHT_RST;
    bit [GAIN_W-1:0] gain_rotation = SCALE_ROTATION_RST;
    bit [CHANS_W-1:0] left_chans = LEFT_CHANNELS_RST;
    bit [CHANS_W-1:0] right_chans = RIGHT_CHANNELS_RST;
    result_t pending_writes[$];
    int errors = 0;

    function int pending();
      return pending_writes.size();
    endfunction

    // Register values are cut to their widths; unmapped indexes change nothing.
    function void set_register(int index, bit [CFG_DATA_W-1:0] value);
      case (index)
        CFG_PWM_MODE:       pwm_mode = value[0];
        CFG_SCALE_STRAIGHT: gain_straight = value[GAIN_W-1:0];
        CFG_SCALE_ROTATION: gain_rotation = value[GAIN_W-1:0];
        CFG_LEFT_CHANNELS:  left_chans = value[CHANS_W-1:0];
        CFG_RIGHT_CHANNELS: right_chans = value[CHANS_W-1:0];
        default: ;
      endcase
    endfunction

    // Turns a channel level in [0, unity] into on/off counts.
    function void push_write(bit [3:0] channel, longint unsigned level);
      result_t r;
      longint unsigned on_c;
      longint unsigned off_c;
      on_c = 0;
      off_c = 0;
      if (level >= UNITY) begin
        on_c = FULL_COUNT;
      end else if (level == 0) begin
        off_c = FULL_COUNT;
      end else begin
        off_c = ((FULL_COUNT - 1) * level) >> (2 * FRACTION_BITS_DEF);
      end
      r.register_address = ADDR_W'(REG_BASE + REG_STRIDE * channel);
      r.on_count = COUNT_W'(on_c);
      r.off_count = COUNT_W'(off_c);
      r.last = 1'b0;
      pending_writes.push_back(r);
    endfunction

    function void motor_writes(bit [CHANS_W-1:0] chans, bit fwd, longint unsigned mag);
      if (pwm_mode) begin
        push_write(chans[3:0], fwd ? 64'd0 : UNITY);
        push_write(chans[7:4], fwd ? UNITY : 64'd0);
        push_write(chans[11:8], mag);
      end else if (mag == 0) begin
        // Brake: both inputs fully on.
        push_write(chans[3:0], UNITY);
        push_write(chans[7:4], UNITY);
      end else if (fwd) begin
        push_write(chans[3:0], UNITY - mag);
        push_write(chans[7:4], UNITY);
      end else begin
        push_write(chans[3:0], UNITY);
        push_write(chans[7:4], UNITY - mag);
      end
    endfunction

    function void predict_channel_writes(cmd_t c);
      bit rotate;
      bit negative;
      bit prod_neg;
      bit left_fwd;
      bit right_fwd;
      bit [THROTTLE_W-1:0] raw;
      bit [GAIN_W-1:0] gain;
      longint unsigned t_mag;
      longint unsigned product;
      longint unsigned mag;
      result_t tail;
      rotate = (c.action == ACT_ROTATE);
      raw = c.throttle;
      negative = raw[THROTTLE_W-1];
      t_mag = negative ? (64'd65536 - longint'(raw)) : longint'(raw);
      gain = rotate ? gain_rotation : gain_straight;
      product = t_mag * gain;
      mag = (product > UNITY) ? UNITY : product;
      // A zero product counts as forward, even on the flipped right motor.
      prod_neg = negative && (product != 0);
      left_fwd = !prod_neg;
      right_fwd = rotate ? (prod_neg || product == 0) : !prod_neg;
      motor_writes(left_chans, left_fwd, mag);
      motor_writes(right_chans, right_fwd, mag);
      tail = pending_writes.pop_back();
      tail.last = 1'b1;
      pending_writes.push_back(tail);
    endfunction

    function void check_channel_write(result_t w);
      result_t e;
      if (pending_writes.size() == 0) begin
        $error("channel write with none expected: addr %0d on %0d off %0d last %0d",
               w.register_address, w.on_count, w.off_count, w.last);
        errors++;
        return;
      end
      e = pending_writes.pop_front();
      if (w.register_address !== e.register_address) begin
        $error("register_address: expected %0d, actual %0d", e.register_address,
               w.register_address);
        errors++;
      end
      if (w.on_count !== e.on_count) begin
        $error("on_count: expected %0d, actual %0d", e.on_count, w.on_count);
        errors++;
      end
      if (w.off_count !== e.off_count) begin
        $error("off_count: expected %0d, actual %0d", e.off_count, w.off_count);
        errors++;
      end
      if (w.last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, w.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic wr_valid;
  logic wr_stall = 1'b0;
  result_t wr;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pwm_write_scoreboard sb = new();
  int stuck_cycles = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_off_request = 1'b0;

  differential_drive_pwm_command_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .wr_valid(wr_valid),
    .wr_stall(wr_stall),
    .wr(wr),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // Items move at rising edges; commands feed the predictor, writes are checked.
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) sb.predict_channel_writes(cmd);
      if (wr_valid && !wr_stall) sb.check_channel_write(wr);
      if ((cmd_valid && !cmd_stall) || (wr_valid && !wr_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Hang detection.
  initial begin
    wait (stuck_cycles >= STALL_LIMIT);
    $display("differential_drive_pwm_command_unit_test: done, errors");
    $finish;
  end

  // Write receiver: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        wr_stall <= 1'b1;
        repeat (48) @(negedge clk);
        wr_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        wr_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        wr_stall <= 1'b0;
      end
    end
  end

  // Offers one command, starting at a falling edge, and returns at the falling
  // edge after it is taken.
  task automatic send_drive(input logic action, input logic signed [THROTTLE_W-1:0] throttle);
    int gap;
    cmd_t c;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    c.action = action;
    c.throttle = throttle;
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // Stops offering commands and waits until every expected write has come out.
  task automatic drain_writes();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // One write with setup and access cycles, then the bus is left idle.
  task automatic cfg_write(input int index, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * index);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(index, value);
    @(negedge clk);
  endtask

  // Writes every register, with random bits above each register's width.
  task automatic program_setting(input logic mode, input logic [GAIN_W-1:0] g_straight,
                                 input logic [GAIN_W-1:0] g_rotation,
                                 input logic [CHANS_W-1:0] left,
                                 input logic [CHANS_W-1:0] right);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    cfg_write(CFG_PWM_MODE, {noise[31:1], mode});
    noise = $urandom;
    cfg_write(CFG_SCALE_STRAIGHT, {noise[31:16], g_straight});
    noise = $urandom;
    cfg_write(CFG_SCALE_ROTATION, {noise[31:16], g_rotation});
    noise = $urandom;
    cfg_write(CFG_LEFT_CHANNELS, {noise[31:12], left});
    noise = $urandom;
    cfg_write(CFG_RIGHT_CHANNELS, {noise[31:12], right});
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return SCALE_STRAIGHT_RST;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHANS_W-1:0] pick_chans();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CHANS_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [THROTTLE_W-1:0] pick_throttle();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return THROTTLE_W'($urandom_range(0, 6)) - 16'sd3;
      default: return THROTTLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: input mode, unit gains. Brake, saturation, exact unity,
    // smallest magnitudes and both signs of rotation.
    send_drive(ACT_FORWARD, 16'sd0);
    send_drive(ACT_FORWARD, 16'sh7FFF);
    send_drive(ACT_FORWARD, 16'sh8000);
    send_drive(ACT_FORWARD, 16'sd1);
    send_drive(ACT_FORWARD, -16'sd1);
    send_drive(ACT_FORWARD, 16'sd16384);
    send_drive(ACT_FORWARD, 16'sd8192);
    send_drive(ACT_ROTATE, 16'sd16384);
    send_drive(ACT_ROTATE, -16'sd8192);
    send_drive(ACT_ROTATE, 16'sd0);
    send_drive(ACT_ROTATE, 16'sh8000);

    // PWM mode with the largest straight gain and zero rotation gain, so that a
    // negative throttle on rotation gives a zero product. The unmapped write
    // must leave the registers alone.
    drain_writes();
    program_setting(1'b1, 16'hFFFF, 16'h0000, 12'hFFF, 12'h000);
    cfg_write(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_drive(ACT_FORWARD, 16'sd1);
    send_drive(ACT_FORWARD, -16'sd1);
    send_drive(ACT_FORWARD, 16'sd0);
    send_drive(ACT_FORWARD, 16'sh8000);
    send_drive(ACT_FORWARD, 16'sd4096);
    send_drive(ACT_ROTATE, 16'sd12345);
    send_drive(ACT_ROTATE, -16'sd12345);

    // Input mode with zero straight gain: a negative throttle brakes.
    drain_writes();
    program_setting(1'b0, 16'h0000, 16'hFFFF, 12'h000, 12'hFFF);
    send_drive(ACT_FORWARD, -16'sd5);
    send_drive(ACT_ROTATE, -16'sd1);
    send_drive(ACT_ROTATE, 16'sd2);
    send_drive(ACT_FORWARD, 16'sh7FFF);

    // Random settings and commands; the last phase runs without idling.
    for (phase = 0; phase < 5; phase++) begin
      drain_writes();
      program_setting(phase == 0 ? 1'b1 : (phase == 1 ? 1'b0 : 1'($urandom_range(0, 1))),
                      pick_gain(), pick_gain(), pick_chans(), pick_chans());
      sender_gaps = (phase != 4);
      receiver_gaps = (phase != 4);
      if (phase == 1) hold_off_request = 1'b1;
      repeat (18) send_drive(1'($urandom_range(0, 1)), pick_throttle());
    end
    drain_writes();
    repeat (12) @(posedge clk);

    if (sb.errors == 0) begin
      $display("differential_drive_pwm_command_unit_test: done, clean");
    end else begin
      $display("differential_drive_pwm_command_unit_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ddp_pkg.sv
rtl/ddp_front.sv
rtl/ddp_queue.sv
rtl/ddp_back.sv
rtl/differential_drive_pwm_command_unit.sv
tb/differential_drive_pwm_command_unit_test.sv
